// ----- hw/rtl/ehc_pkg.sv -----
// Package with shared constants, types and the CORDIC arctangent table.
`default_nettype none
package ehc_pkg;
    localparam int unsigned TurnBits = 32;
    localparam int unsigned VecBits  = 40;
    localparam int unsigned QShift   = 30;
    localparam logic signed [VecBits-1:0] GainComp = 40'sd652032874;
    localparam logic [TurnBits-1:0] TurnHalf    = 32'h8000_0000;
    localparam logic [TurnBits-1:0] TurnQuarter = 32'h4000_0000;
    localparam logic ReqToHorizontal = 1'b0;
    localparam logic ReqToEquatorial = 1'b1;

    typedef logic signed [VecBits-1:0] t_vec;
    typedef logic [TurnBits-1:0] t_turn;

    // Stage angle atan(2^-i) in units of a 2^32 full turn.
    function automatic t_turn stage_angle(input logic [4:0] i);
        t_turn a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Product of two Q30 values, shifted back to Q30 (rounds toward minus infinity).
    // Every operand stays below 2^31 in magnitude, so a 32 by 32 multiply suffices.
    function automatic t_vec mulq(input t_vec a, input t_vec b);
        logic signed [31:0] a32, b32;
        logic signed [63:0] p;
        a32 = a[31:0];
        b32 = b[31:0];
        p = a32 * b32;
        return t_vec'(p >>> QShift);
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/ehc_stream_if.sv -----
// Valid/ready stream interface carrying a payload word.
`default_nettype none
interface ehc_stream_if #(
    parameter int unsigned WIDTH = 48
) (
    input wire logic i_clk
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/equatorial_horizontal_convert.sv -----
// Top level: coordinate converter pipeline between equatorial and horizontal, direction chosen per request.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: synchronous active-low i_rst_n clears valid bits and the latitude register.
`default_nettype none
module equatorial_horizontal_convert #(
    parameter int unsigned ANGLE_BITS    = 24,
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ehc_stream_if.sink                 i_req,
    ehc_stream_if.source               o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [1:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);
    localparam int unsigned Sh    = ehc_pkg::TurnBits - ANGLE_BITS;
    localparam int unsigned Depth = 3*CORDIC_STAGES + 8;
    localparam logic [1:0]  AddrLatitude = 2'd0;

    typedef ehc_pkg::t_vec  t_vec;
    typedef ehc_pkg::t_turn t_turn;

    logic [ANGLE_BITS-1:0] r_lat;
    logic                  adv;
    logic [Depth-1:0]      r_vld;
    logic                  r_ovld;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == AddrLatitude) ? 32'(r_lat) : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= '0;
        end else if (psel && penable && pwrite && paddr == AddrLatitude) begin
            r_lat <= pwdata[ANGLE_BITS-1:0];
        end
    end

    // Pipeline advances whenever the output register can take a word.
    assign adv         = !r_ovld || o_res.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (adv) begin
                r_vld  <= {r_vld[Depth-2:0], i_req.valid};
                r_ovld <= r_vld[Depth-1];
            end
        end
    end

    // Input unpacking and angle preparation for the rotation CORDICs.
    logic                  in_type;
    logic [ANGLE_BITS-1:0] in_a1, in_a2;
    t_turn a1, a2, lt, ta, tb, tc;
    t_turn za, zb, zc;
    logic  fa, fb, fc;
    assign in_type = i_req.data[2*ANGLE_BITS];
    assign in_a1   = i_req.data[2*ANGLE_BITS-1:ANGLE_BITS];
    assign in_a2   = i_req.data[ANGLE_BITS-1:0];
    always_comb begin
        a1 = t_turn'(in_a1) << Sh;
        a2 = t_turn'(in_a2) << Sh;
        lt = t_turn'(r_lat) << Sh;
        ta = a2;
        tb = lt;
        tc = (in_type == ehc_pkg::ReqToEquatorial) ? ehc_pkg::TurnHalf - a1 : 32'd0 - a1;
        fa = ta[31] ^ ta[30];
        fb = tb[31] ^ tb[30];
        fc = tc[31] ^ tc[30];
        za = fa ? ta - ehc_pkg::TurnHalf : ta;
        zb = fb ? tb - ehc_pkg::TurnHalf : tb;
        zc = fc ? tc - ehc_pkg::TurnHalf : tc;
    end

    // Sine and cosine of declination, latitude and hour angle.
    t_vec  xa, ya, xb, yb, xc, yc;
    t_turn unz_a, unz_b, unz_c;
    logic  ofa, ofb, ofc;
    ehc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot_a (
        .i_clk, .i_en(adv), .i_x(ehc_pkg::GainComp), .i_y('0), .i_z(za), .i_flip(fa),
        .o_x(xa), .o_y(ya), .o_z(unz_a), .o_flip(ofa));
    ehc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot_b (
        .i_clk, .i_en(adv), .i_x(ehc_pkg::GainComp), .i_y('0), .i_z(zb), .i_flip(fb),
        .o_x(xb), .o_y(yb), .o_z(unz_b), .o_flip(ofb));
    ehc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot_c (
        .i_clk, .i_en(adv), .i_x(ehc_pkg::GainComp), .i_y('0), .i_z(zc), .i_flip(fc),
        .o_x(xc), .o_y(yc), .o_z(unz_c), .o_flip(ofc));

    // Request type follows the words through the pipeline.
    logic r_ty [Depth+1];
    always_ff @(posedge i_clk) begin
        if (adv) r_ty[0] <= in_type;
    end
    for (genvar g = 0; g < Depth; g++) begin : g_ty
        always_ff @(posedge i_clk) begin
            if (adv) r_ty[g+1] <= r_ty[g];
        end
    end
    localparam int unsigned P1 = CORDIC_STAGES + 1;

    // Stage P1: sign-corrected sines and cosines.
    t_vec r_c2, r_s2, r_cl, r_sl, r_c1, r_s1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c2 <= ofa ? -xa : xa;
            r_s2 <= ofa ? -ya : ya;
            r_cl <= ofb ? -xb : xb;
            r_sl <= ofb ? -yb : yb;
            r_c1 <= ofc ? -xc : xc;
            r_s1 <= ofc ? -yc : yc;
        end
    end

    // Stage P1+1: unit vector.
    t_vec r_x, r_y, r_z, r_cl2, r_sl2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x   <= ehc_pkg::mulq(r_c1, r_c2);
            r_y   <= ehc_pkg::mulq(r_s1, r_c2);
            r_z   <= r_s2;
            r_cl2 <= r_cl;
            r_sl2 <= r_sl;
        end
    end

    // Stage P1+2: rotation products; stage P1+3: sums.
    t_vec r_xs, r_zc, r_xc, r_zs, r_y3, r_y4, r_x2, r_z2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xs <= ehc_pkg::mulq(r_x, r_sl2);
            r_zc <= ehc_pkg::mulq(r_z, r_cl2);
            r_xc <= ehc_pkg::mulq(r_x, r_cl2);
            r_zs <= ehc_pkg::mulq(r_z, r_sl2);
            r_y3 <= r_y;
            r_y4 <= r_y3;
            if (r_ty[P1+2] == ehc_pkg::ReqToEquatorial) begin
                r_x2 <= r_xs + r_zc;
                r_z2 <= r_zs - r_xc;
            end else begin
                r_x2 <= r_xs - r_zc;
                r_z2 <= r_xc + r_zs;
            end
        end
    end

    // First vectoring CORDIC: azimuth-like angle and horizontal radius.
    logic  v1_zero, v1_neg;
    t_vec  v1_x, v1_y, o1_x, o1_y;
    t_turn v1_z, o1_z;
    logic  o1_zero;
    always_comb begin
        v1_zero = (r_x2 == '0) && (r_y4 == '0);
        v1_neg  = r_x2[ehc_pkg::VecBits-1];
        v1_x    = v1_neg ? -r_x2 : r_x2;
        v1_y    = v1_neg ? -r_y4 : r_y4;
        v1_z    = v1_neg ? ehc_pkg::TurnHalf : '0;
    end
    ehc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_vec1 (
        .i_clk, .i_en(adv), .i_x(v1_x), .i_y(v1_y), .i_z(v1_z), .i_flip(v1_zero),
        .o_x(o1_x), .o_y(o1_y), .o_z(o1_z), .o_flip(o1_zero));
    localparam int unsigned P2 = 2*CORDIC_STAGES + 5;

    // Pipeline z2 alongside the first vectoring pass.
    t_vec r_zd [CORDIC_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (adv) r_zd[0] <= r_z2;
    end
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_zd
        always_ff @(posedge i_clk) begin
            if (adv) r_zd[g+1] <= r_zd[g];
        end
    end

    // Magnitude scaling and longitude register.
    t_vec  r_mag, r_zz;
    t_turn r_lon;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mag <= o1_zero ? '0 : ehc_pkg::mulq(o1_x, ehc_pkg::GainComp);
            r_zz  <= r_zd[CORDIC_STAGES];
            r_lon <= o1_zero ? '0 : o1_z;
        end
    end

    // Second vectoring CORDIC: latitude-like angle.
    logic  v2_zero;
    t_vec  v2_x, o2_x, o2_y;
    t_turn o2_z;
    logic  o2_zero;
    always_comb begin
        v2_x    = r_mag[ehc_pkg::VecBits-1] ? '0 : r_mag;
        v2_zero = (v2_x == '0) && (r_zz == '0);
    end
    ehc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_vec2 (
        .i_clk, .i_en(adv), .i_x(v2_x), .i_y(r_zz), .i_z('0), .i_flip(v2_zero),
        .o_x(o2_x), .o_y(o2_y), .o_z(o2_z), .o_flip(o2_zero));

    t_turn r_lond [CORDIC_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (adv) r_lond[0] <= r_lon;
    end
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_ld
        always_ff @(posedge i_clk) begin
            if (adv) r_lond[g+1] <= r_lond[g];
        end
    end

    // Final rounding and saturation into the output register.
    t_turn lon_f, lon_r, lat_t;
    logic signed [32:0] lat_s, lat_r;
    localparam t_turn HalfLsb = (Sh > 0) ? t_turn'(1) << (Sh - 1) : '0;
    always_comb begin
        lon_f = (r_ty[Depth-1] == ehc_pkg::ReqToEquatorial) ? 32'd0 - r_lond[CORDIC_STAGES]
                : ehc_pkg::TurnHalf - r_lond[CORDIC_STAGES];
        lon_r = lon_f + HalfLsb;
        lat_t = o2_zero ? '0 : o2_z;
        lat_s = 33'(signed'(lat_t));
        if (lat_s > 33'sh0_4000_0000) lat_s = 33'sh0_4000_0000;
        if (lat_s < -33'sh0_4000_0000) lat_s = -33'sh0_4000_0000;
        lat_r = (lat_s + 33'(HalfLsb)) >>> Sh;
    end
    logic [ANGLE_BITS-1:0] r_o1, r_o2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o1 <= lon_r[31 -: ANGLE_BITS];
            r_o2 <= lat_r[ANGLE_BITS-1:0];
        end
    end
    assign o_res.valid = r_ovld;
    assign o_res.data  = {r_o1, r_o2};

    // Unused CORDIC residues.
    logic unused;
    assign unused = ^{unz_a, unz_b, unz_c, o1_y, o2_x, o2_y, r_ty[Depth], P2[0]};
endmodule
`default_nettype wire

// ----- hw/rtl/ehc_cordic.sv -----
// Pipelined CORDIC engine: rotation (cosine/sine) or vectoring (atan2, magnitude).
`default_nettype none
module ehc_cordic #(
    parameter int unsigned STAGES    = 24,
    parameter bit          VECTORING = 1'b0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire ehc_pkg::t_vec  i_x,
    input  wire ehc_pkg::t_vec  i_y,
    input  wire ehc_pkg::t_turn i_z,
    input  wire logic           i_flip,
    output ehc_pkg::t_vec       o_x,
    output ehc_pkg::t_vec       o_y,
    output ehc_pkg::t_turn      o_z,
    output logic                o_flip
);
    ehc_pkg::t_vec  r_x [STAGES+1];
    ehc_pkg::t_vec  r_y [STAGES+1];
    ehc_pkg::t_turn r_z [STAGES+1];
    logic           r_f [STAGES+1];

    // Stage zero is the registered input.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= i_z;
            r_f[0] <= i_flip;
        end
    end

    // One micro-rotation per register stage.
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int unsigned Sh = (g < 32) ? g : 31;
        logic           pos;
        ehc_pkg::t_turn ang;
        always_comb begin
            ang = (g < 32) ? ehc_pkg::stage_angle(5'(Sh)) : '0;
            if (VECTORING) pos = !r_y[g][ehc_pkg::VecBits-1];
            else           pos = !r_z[g][ehc_pkg::TurnBits-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[g+1] <= r_f[g];
                if (pos ^ VECTORING) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> Sh);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> Sh);
                    r_z[g+1] <= r_z[g] - ang;
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> Sh);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> Sh);
                    r_z[g+1] <= r_z[g] + ang;
                end
            end
        end
    end

    assign o_x    = r_x[STAGES];
    assign o_y    = r_y[STAGES];
    assign o_z    = r_z[STAGES];
    assign o_flip = r_f[STAGES];
endmodule
`default_nettype wire

// ----- hw/rtl/ehc_checker.sv -----
// Port-level checker for the converter, bound to the top level.
`default_nettype none
module ehc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [47:0] out_data
);
    // A waiting word holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");
    // The input is ready whenever the output is not stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled without output back-pressure");
    // A stall at the output stalls the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");
    // No word appears straight after reset.
    assert property (@(posedge i_clk) $rose(i_rst_n) |-> !out_valid)
        else $error("output valid out of reset");
endmodule

bind equatorial_horizontal_convert ehc_checker u_ehc_checker (
    .i_clk, .i_rst_n, .in_ready(i_req.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready), .out_data(o_res.data));
`default_nettype wire
